### design/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg
// Shared constants and controller/datapath interface types for the moving
// average filter.
// ----------------------------------------------------------------------------
package maf_pkg;

  // Deepest window that the sample store holds.
  localparam int MAX_WINDOW = 255;

  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 8;
  localparam int SUM_W    = 24;
  localparam int ADDR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

  // The divider retires one quotient bit per cycle.
  localparam int DIV_STEPS = SUM_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take a new item and start the store read
    logic zero;      // take a new item with a zero window, result is zero
    logic update;    // update the sum, write the store, load the divider
    logic step;      // one divider iteration
    logic load_out;  // move the quotient into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_zero;  // window length is zero
    logic out_free;  // output register can take a new result this cycle
  } sts_t;

endpackage

### design/maf_ram.sv
// ----------------------------------------------------------------------------
// maf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module maf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/maf_dpath.sv
// ----------------------------------------------------------------------------
// maf_dpath
// Datapath of the moving average filter: window register, sample store with
// valid bits, running sum, bit-serial divider and output register.
// ----------------------------------------------------------------------------
module maf_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [maf_pkg::LEN_W-1:0]     window_length_i,
  input  logic [maf_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                          average_stall_i,
  output logic                          average_valid_o,
  output logic [maf_pkg::SAMPLE_W-1:0]  average_o,
  input  maf_pkg::cmd_t                 cmd_i,
  output maf_pkg::sts_t                 sts_o
);

  logic [maf_pkg::LEN_W-1:0]      win_len_q;
  logic [maf_pkg::LEN_W-1:0]      len_eff;
  logic [maf_pkg::ADDR_W-1:0]     pos_q, pos_d;
  logic [maf_pkg::ADDR_W-1:0]     pos_eff;
  logic [maf_pkg::ADDR_W-1:0]     cur_pos_q;
  logic [maf_pkg::LEN_W:0]        next_pos;
  logic [maf_pkg::MAX_WINDOW-1:0] vld_q;
  logic                           vld_rd_q;
  logic [maf_pkg::SAMPLE_W-1:0]   sample_q;
  logic [maf_pkg::SAMPLE_W-1:0]   rd_data;
  logic [maf_pkg::SAMPLE_W-1:0]   old_sample;
  logic [maf_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic [maf_pkg::LEN_W-1:0]      rem_q;
  logic [maf_pkg::SUM_W-1:0]      quot_q;
  logic [maf_pkg::LEN_W:0]        trial;
  logic                           trial_ge;
  logic [maf_pkg::LEN_W:0]        trial_sub;
  logic [maf_pkg::SAMPLE_W-1:0]   quot_sat;
  logic                           out_valid_q;
  logic [maf_pkg::SAMPLE_W-1:0]   avg_q;

  // Window length, saturated to the store depth.
  always_comb begin
    if ({1'b0, win_len_q} > (maf_pkg::LEN_W + 1)'(maf_pkg::MAX_WINDOW)) begin
      len_eff = maf_pkg::LEN_W'(maf_pkg::MAX_WINDOW);
    end else begin
      len_eff = win_len_q;
    end
  end

  // The write position restarts at zero if the window was made shorter.
  assign pos_eff = (maf_pkg::LEN_W'(pos_q) >= len_eff) ? '0 : pos_q;

  // Position after the current one, wrapped at the window length.
  assign next_pos = (maf_pkg::LEN_W + 1)'(cur_pos_q) + 1'b1;
  assign pos_d    = (next_pos >= {1'b0, len_eff}) ? '0 : maf_pkg::ADDR_W'(next_pos);

  maf_ram #(
    .WIDTH (maf_pkg::SAMPLE_W),
    .DEPTH (maf_pkg::MAX_WINDOW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (cur_pos_q),
    .wdata_i (sample_q),
    .re_i    (cmd_i.accept),
    .raddr_i (pos_eff),
    .rdata_o (rd_data)
  );

  // Entries never written since reset read as zero.
  assign old_sample = vld_rd_q ? rd_data : '0;
  assign sum_d      = sum_q - maf_pkg::SUM_W'(old_sample) + maf_pkg::SUM_W'(sample_q);

  // Restoring division step: the partial remainder stays below the divisor.
  assign trial     = {rem_q, quot_q[maf_pkg::SUM_W-1]};
  assign trial_ge  = trial >= {1'b0, len_eff};
  assign trial_sub = trial - {1'b0, len_eff};

  assign quot_sat = (|quot_q[maf_pkg::SUM_W-1:maf_pkg::SAMPLE_W]) ? '1
                  : quot_q[maf_pkg::SAMPLE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= maf_pkg::LEN_RESET;
      pos_q       <= '0;
      sum_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        win_len_q <= window_length_i;
      end
      if (cmd_i.update) begin
        sum_q            <= sum_d;
        pos_q            <= pos_d;
        vld_q[cur_pos_q] <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!average_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q  <= sample_i;
      cur_pos_q <= pos_eff;
      vld_rd_q  <= vld_q[pos_eff];
    end
    if (cmd_i.zero) begin
      quot_q <= '0;
    end else if (cmd_i.update) begin
      quot_q <= sum_d;
      rem_q  <= '0;
    end else if (cmd_i.step) begin
      quot_q <= {quot_q[maf_pkg::SUM_W-2:0], trial_ge};
      rem_q  <= trial_ge ? trial_sub[maf_pkg::LEN_W-1:0] : trial[maf_pkg::LEN_W-1:0];
    end
    if (cmd_i.load_out) begin
      avg_q <= quot_sat;
    end
  end

  assign sts_o.len_zero  = (len_eff == '0);
  assign sts_o.out_free  = !out_valid_q || !average_stall_i;
  assign average_valid_o = out_valid_q;
  assign average_o       = avg_q;

`ifndef SYNTHESIS
  a_out_rise_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.load_out))
    else $error("output valid rose without a result load");

  a_out_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && average_stall_i && !cmd_i.load_out |=> out_valid_q && $stable(avg_q))
    else $error("stalled result was lost or changed");

  a_write_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> vld_q[$past(cur_pos_q)])
    else $error("store write did not set the entry valid bit");
`endif

endmodule

### design/maf_ctrl.sv
// ----------------------------------------------------------------------------
// maf_ctrl
// Controller of the moving average filter: sequences item acceptance, the
// sum update, the divider iterations and the hand-off to the output register.
// ----------------------------------------------------------------------------
module maf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          sample_valid_i,
  output logic          sample_stall_o,
  output maf_pkg::cmd_t cmd_o,
  input  maf_pkg::sts_t sts_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [maf_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                      take;

  assign take = (state_q == S_IDLE) && sample_valid_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (take) begin
          if (sts_i.len_zero) begin
            cmd_o.zero = 1'b1;
            state_d    = S_DONE;
          end else begin
            cmd_o.accept = 1'b1;
            state_d      = S_UPD;
          end
        end
      end
      S_UPD: begin
        cmd_o.update = 1'b1;
        cnt_d        = '0;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == maf_pkg::CNT_W'(maf_pkg::DIV_STEPS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign sample_stall_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  a_accept_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !sts_i.len_zero |=> state_q == S_UPD)
    else $error("accepted item did not move to the update step");

  a_div_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q < maf_pkg::CNT_W'(maf_pkg::DIV_STEPS))
    else $error("divider step count out of range");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.out_free && state_q == S_DONE)
    else $error("result loaded while the output register was busy");

  a_div_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && state_d == S_DONE
      |-> cnt_q == maf_pkg::CNT_W'(maf_pkg::DIV_STEPS - 1))
    else $error("divider left before all quotient bits were formed");
`endif

endmodule

### design/moving_average_filter.sv
// ----------------------------------------------------------------------------
// moving_average_filter
// Simple moving average over the last window_length unsigned 16-bit samples,
// truncated, with a zero window giving a zero result.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                       Payload
//   sample    in         sample_valid_i / sample_stall_o   sample_i[15:0]
//   average   out        average_valid_o / average_stall_i average_o[15:0]
//   cfg       in         cfg_valid_i / cfg_ready_o         window_length_i[7:0]
//
// An item with a nonzero window passes through these steps from acceptance
// to the point where the next item can be taken: a read of the store, an
// update of the running sum, the one-bit-per-cycle divider and the hand-off
// of the quotient to the output register. A zero window skips all but the last.
// Reset is asynchronous and active low; the store is not swept, per-entry
// valid bits make unwritten entries read as zero, so no clearing pass runs.
// A result waits in the output register while average_stall_i is high, and
// the next item is accepted and processed meanwhile; it only waits at the end
// if the previous result has still not been taken.
//
module moving_average_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  window_length_i,
  // Sample input.
  input  logic        sample_valid_i,
  output logic        sample_stall_o,
  input  logic [15:0] sample_i,
  // Average output.
  output logic        average_valid_o,
  input  logic        average_stall_i,
  output logic [15:0] average_o
);

  maf_pkg::cmd_t cmd;
  maf_pkg::sts_t sts;

  // The window register is written only while no item is being processed
  // and none is being offered, so an item always sees one window length
  // from its acceptance to its result.
  assign cfg_ready_o = !sample_stall_o && !sample_valid_i;

  maf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  maf_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i && cfg_ready_o),
    .window_length_i (window_length_i),
    .sample_i        (sample_i),
    .average_stall_i (average_stall_i),
    .average_valid_o (average_valid_o),
    .average_o       (average_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule
